/* src/bce_pkg.sv */
`default_nettype none

package bce_pkg;

    localparam int TABLE_POINTS = 21;
    localparam int IDX_W        = $clog2(TABLE_POINTS);
    localparam int DIV_BITS     = 16;
    localparam int CNT_W        = $clog2(DIV_BITS);

    localparam logic [16:0] OLD_WEIGHT  = 17'd64553;
    localparam logic [16:0] NEW_WEIGHT  = 17'd983;
    localparam logic [9:0]  CHARGE_FULL = 10'd1000;
    localparam logic [9:0]  CHARGE_NONE = 10'd0;
    localparam logic [3:0]  CELLS_RESET = 4'd4;

    // descending cell voltage (mV) and matching charge (per mille)
    localparam logic [15:0] TABLE_MV [TABLE_POINTS] = '{
        16'd4200, 16'd4150, 16'd4110, 16'd4080, 16'd4020, 16'd3980, 16'd3950,
        16'd3910, 16'd3870, 16'd3850, 16'd3840, 16'd3820, 16'd3800, 16'd3790,
        16'd3770, 16'd3750, 16'd3730, 16'd3710, 16'd3690, 16'd3610, 16'd3270
    };
    localparam logic [9:0] TABLE_PM [TABLE_POINTS] = '{
        10'd1000, 10'd950, 10'd900, 10'd850, 10'd800, 10'd750, 10'd700,
        10'd650,  10'd600, 10'd550, 10'd500, 10'd450, 10'd400, 10'd350,
        10'd300,  10'd250, 10'd200, 10'd150, 10'd100, 10'd50,  10'd0
    };

    typedef enum logic [0:0] {
        ALU_MUL,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [48:0] res;
        logic        borrow;
    } t_alu_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_DIV_INIT,
        ST_DIV,
        ST_CHK_TOP,
        ST_CHK_BOT,
        ST_WALK,
        ST_MUL_SPAN,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

/* src/bce_alu.sv */
`default_nettype none

module bce_alu
    import bce_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic [32:0] diff;

    assign diff = {1'b0, i_req.a} - {1'b0, i_req.b};

    always_comb begin
        case (i_req.op)
            ALU_MUL: begin
                o_rsp.res    = {17'd0, i_req.a} * {32'd0, i_req.b[16:0]};
                o_rsp.borrow = 1'b0;
            end
            ALU_SUB: begin
                o_rsp.res    = {17'd0, diff[31:0]};
                o_rsp.borrow = diff[32];
            end
            default: begin
                o_rsp.res    = '0;
                o_rsp.borrow = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/battery_charge_estimator_core.sv */
`default_nettype none
// Each sample runs as a sequence of states on one shared ALU: the filter multiplies (skipped
// for the first sample, which loads the filter), a restoring divide of the filtered pack
// voltage by the cell count, the top and bottom clamp checks and, when interpolating, the
// table walk, a span multiply and a second restoring divide.
// Throughput: next beat is taken after a result is queued.
// Reset (synchronous, active low): filter empty, cell count 4, no result pending.

module battery_charge_estimator_core
    import bce_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [3:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] sample_mv
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata    // [15:0] filtered_mv, [31:16] cell_mv,
                                        // [41:32] charge_permille, [47:42] zero
);

    t_state          r_state, n_state;
    logic            r_loaded, n_loaded;
    logic [3:0]      r_cells;
    logic [31:0]     r_avg, n_avg;
    logic [48:0]     r_acc, n_acc;
    logic [15:0]     r_samp, n_samp;
    logic [15:0]     r_dvd, n_dvd;
    logic [15:0]     r_dvs, n_dvs;
    logic [15:0]     r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic            r_phase, n_phase;
    logic [15:0]     r_cell, n_cell;
    logic [15:0]     r_diff, n_diff;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [9:0]      r_charge, n_charge;
    logic            r_m_valid, n_m_valid;
    logic [15:0]     r_out_filt, n_out_filt;
    logic [15:0]     r_out_cell, n_out_cell;
    logic [9:0]      r_out_charge, n_out_charge;

    t_alu_req        alu_req;
    t_alu_rsp        alu_rsp;
    logic [16:0]     trial;
    logic [15:0]     q_next;
    logic [16:0]     pm_sum;
    logic [48:0]     mix_sum;

    bce_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_out_charge, r_out_cell, r_out_filt};

    assign trial   = {r_rem, r_dvd[DIV_BITS-1]};
    assign q_next  = {r_dvd[DIV_BITS-2:0], ~alu_rsp.borrow};
    assign pm_sum  = {7'd0, TABLE_PM[r_idx]} + {1'b0, q_next};
    assign mix_sum = r_acc + {alu_rsp.res[32:0], 16'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_loaded  <= 1'b0;
            r_cells   <= CELLS_RESET;
            r_avg     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_loaded  <= n_loaded;
            r_avg     <= n_avg;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid) begin
                r_cells <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_samp       <= n_samp;
        r_dvd        <= n_dvd;
        r_dvs        <= n_dvs;
        r_rem        <= n_rem;
        r_cnt        <= n_cnt;
        r_phase      <= n_phase;
        r_cell       <= n_cell;
        r_diff       <= n_diff;
        r_idx        <= n_idx;
        r_charge     <= n_charge;
        r_out_filt   <= n_out_filt;
        r_out_cell   <= n_out_cell;
        r_out_charge <= n_out_charge;
    end

    always_comb begin
        n_state      = r_state;
        n_loaded     = r_loaded;
        n_avg        = r_avg;
        n_acc        = r_acc;
        n_samp       = r_samp;
        n_dvd        = r_dvd;
        n_dvs        = r_dvs;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_phase      = r_phase;
        n_cell       = r_cell;
        n_diff       = r_diff;
        n_idx        = r_idx;
        n_charge     = r_charge;
        n_out_filt   = r_out_filt;
        n_out_cell   = r_out_cell;
        n_out_charge = r_out_charge;
        n_m_valid    = r_m_valid;
        alu_req.op   = ALU_SUB;
        alu_req.a    = '0;
        alu_req.b    = '0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_samp = s_axis_tdata;
                    if (!r_loaded) begin
                        n_avg    = {s_axis_tdata, 16'd0};
                        n_loaded = 1'b1;
                        n_state  = ST_DIV_INIT;
                    end else begin
                        n_state = ST_MUL_OLD;
                    end
                end
            end
            ST_MUL_OLD: begin
                alu_req.op = ALU_MUL;
                alu_req.a  = r_avg;
                alu_req.b  = {15'd0, OLD_WEIGHT};
                n_acc      = alu_rsp.res;
                n_state    = ST_MUL_NEW;
            end
            ST_MUL_NEW: begin
                alu_req.op = ALU_MUL;
                alu_req.a  = {16'd0, r_samp};
                alu_req.b  = {15'd0, NEW_WEIGHT};
                n_avg      = mix_sum[47:16];
                n_state    = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                n_dvd   = r_avg[31:16];
                n_dvs   = (r_cells == 4'd0) ? 16'd1 : {12'd0, r_cells};
                n_rem   = '0;
                n_cnt   = '0;
                n_phase = 1'b0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // one restoring step per cycle
                alu_req.op = ALU_SUB;
                alu_req.a  = {15'd0, trial};
                alu_req.b  = {16'd0, r_dvs};
                n_rem      = alu_rsp.borrow ? trial[15:0] : alu_rsp.res[15:0];
                n_dvd      = q_next;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                    if (!r_phase) begin
                        n_cell  = q_next;
                        n_state = ST_CHK_TOP;
                    end else begin
                        n_charge = (pm_sum > {7'd0, CHARGE_FULL}) ? CHARGE_FULL : pm_sum[9:0];
                        n_state  = ST_FIN;
                    end
                end
            end
            ST_CHK_TOP: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {16'd0, r_cell};
                alu_req.b  = {16'd0, TABLE_MV[0]};
                if (!alu_rsp.borrow) begin
                    n_charge = CHARGE_FULL;
                    n_state  = ST_FIN;
                end else begin
                    n_state = ST_CHK_BOT;
                end
            end
            ST_CHK_BOT: begin
                alu_req.op = ALU_SUB;
                alu_req.a  = {16'd0, TABLE_MV[TABLE_POINTS-1]};
                alu_req.b  = {16'd0, r_cell};
                if (!alu_rsp.borrow) begin
                    n_charge = CHARGE_NONE;
                    n_state  = ST_FIN;
                end else begin
                    n_idx   = IDX_W'(1);
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                // stops at the first point at or below the cell voltage
                alu_req.op = ALU_SUB;
                alu_req.a  = {16'd0, r_cell};
                alu_req.b  = {16'd0, TABLE_MV[r_idx]};
                if (!alu_rsp.borrow) begin
                    n_diff  = alu_rsp.res[15:0];
                    n_state = ST_MUL_SPAN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_MUL_SPAN: begin
                alu_req.op = ALU_MUL;
                alu_req.a  = {16'd0, r_diff};
                alu_req.b  = {22'd0, TABLE_PM[r_idx - 1'b1] - TABLE_PM[r_idx]};
                n_dvd      = alu_rsp.res[15:0];
                n_dvs      = TABLE_MV[r_idx - 1'b1] - TABLE_MV[r_idx];
                n_rem      = '0;
                n_cnt      = '0;
                n_phase    = 1'b1;
                n_state    = ST_DIV;
            end
            ST_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_out_filt   = r_avg[31:16];
                    n_out_cell   = r_cell;
                    n_out_charge = r_charge;
                    n_m_valid    = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/bce_checker.sv */
`default_nettype none

module bce_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata
);

    // busy while a sample is being worked
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_charge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[41:32] <= 10'd1000)
        else $error("charge above 1000 per mille");

    a_cell_le_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:16] <= m_axis_tdata[15:0])
        else $error("cell voltage above pack voltage");

endmodule

bind battery_charge_estimator_core bce_checker u_bce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
